FILE: hw/rtl/hcsg_pkg.sv
// ----------------------------------------------------------------------------
// hcsg_pkg
// Shared types, constants and decode functions of the Hilbert curve step
// generator.
// ----------------------------------------------------------------------------
package hcsg_pkg;

   localparam int MAX_ORDER  = 16;
   localparam int INDEX_W    = 2 * MAX_ORDER;
   localparam int ORDER_W    = $clog2(MAX_ORDER + 1);
   localparam int SHAMT_W    = $clog2(INDEX_W + 1);
   localparam int CFG_W      = 5;
   localparam int DIR_W      = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_CURVE_ORDER = 1'b0;

   localparam logic [CFG_W-1:0] CURVE_ORDER_RESET = CFG_W'(1);

   typedef enum logic [DIR_W-1:0] {
      DIR_0   = 2'd0,
      DIR_90  = 2'd1,
      DIR_180 = 2'd2,
      DIR_270 = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      SYM_A = 2'd0,
      SYM_B = 2'd1,
      SYM_C = 2'd2,
      SYM_D = 2'd3
   } sym_type;

   // item held between the index stage and the direction decode
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
      logic [ORDER_W-1:0] order;
      logic               last;
   } stage_type;

   // the child symbol of quadrant q is the parent symbol xor this mask:
   // quadrant 0 swaps A<->D and B<->C, quadrant 3 swaps A<->B and C<->D
   function automatic logic [1:0] sym_flip(input logic [1:0] quad);
      logic [1:0] flip;
      case (quad)
         2'd0:    flip = 2'd3;
         2'd3:    flip = 2'd1;
         default: flip = 2'd0;
      endcase
      return flip;
   endfunction

   // direction of the joining step after quadrant q of a block of symbol sym
   function automatic dir_type join_dir(input sym_type sym, input logic [1:0] quad);
      dir_type d;
      d = DIR_0;
      unique case (sym)
         SYM_A: begin
            case (quad)
               2'd0:    d = DIR_180;
               2'd1:    d = DIR_270;
               default: d = DIR_0;
            endcase
         end
         SYM_B: begin
            case (quad)
               2'd0:    d = DIR_90;
               2'd1:    d = DIR_0;
               default: d = DIR_270;
            endcase
         end
         SYM_C: begin
            case (quad)
               2'd0:    d = DIR_0;
               2'd1:    d = DIR_90;
               default: d = DIR_180;
            endcase
         end
         SYM_D: begin
            case (quad)
               2'd0:    d = DIR_270;
               2'd1:    d = DIR_180;
               default: d = DIR_90;
            endcase
         end
         default: d = DIR_0;
      endcase
      return d;
   endfunction

endpackage

FILE: hw/rtl/hcsg_if.sv
// ----------------------------------------------------------------------------
// hcsg request and response channels
// Valid/ready channels of the step generator, one beat per item.
// ----------------------------------------------------------------------------
interface hcsg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface hcsg_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] direction;
   logic       last_step;

   modport source (output valid, output direction, output last_step, input ready);
   modport sink   (input valid, input direction, input last_step, output ready);
endinterface

FILE: hw/rtl/hcsg_index.sv
// ----------------------------------------------------------------------------
// hcsg_index
// Step counter: picks the index of each accepted request and registers it
// together with the effective order and the last-step flag.
// ----------------------------------------------------------------------------
module hcsg_index (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_restart,
   input  logic                      load_en,
   input  logic [hcsg_pkg::CFG_W-1:0] curve_order,
   output hcsg_pkg::stage_type       stage
);
   import hcsg_pkg::*;

   logic [INDEX_W-1:0] step_index_ff;
   logic [INDEX_W-1:0] step_index_in;
   stage_type          stage_ff;
   stage_type          stage_in;

   logic [ORDER_W-1:0] eff_order;
   logic [SHAMT_W-1:0] shamt;
   logic [INDEX_W-1:0] total;
   logic [INDEX_W-1:0] use_index;
   logic               is_last;
   logic               accept;

   always_comb begin
      if (curve_order == '0) begin
         eff_order = ORDER_W'(1);
      end else if (curve_order > CFG_W'(MAX_ORDER)) begin
         eff_order = ORDER_W'(MAX_ORDER);
      end else begin
         eff_order = curve_order[ORDER_W-1:0];
      end
      shamt = SHAMT_W'({eff_order, 1'b0});
      // 4^order - 1 steps; a shift by the full width leaves all ones
      total = ~({INDEX_W{1'b1}} << shamt);
   end

   assign accept = in_valid && load_en;

   always_comb begin
      // restart, or an order change that left the index past the end
      if (in_restart || (step_index_ff >= total)) begin
         use_index = '0;
      end else begin
         use_index = step_index_ff;
      end
      is_last = (use_index == (total - INDEX_W'(1)));

      step_index_in = step_index_ff;
      stage_in      = stage_ff;
      if (load_en) begin
         stage_in.valid = in_valid;
      end
      if (accept) begin
         step_index_in  = is_last ? '0 : use_index + INDEX_W'(1);
         stage_in.index = use_index;
         stage_in.order = eff_order;
         stage_in.last  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff  <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         step_index_ff  <= step_index_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.index <= stage_in.index;
      stage_ff.order <= stage_in.order;
      stage_ff.last  <= stage_in.last;
   end

   assign stage = stage_ff;

endmodule

FILE: hw/rtl/hcsg_dir.sv
// ----------------------------------------------------------------------------
// hcsg_dir
// Direction decode: finds the curve level at which the step lies, the
// symbol of that block from the digits above it, and registers the result.
// ----------------------------------------------------------------------------
module hcsg_dir (
   input  logic                clock,
   input  logic                reset,
   input  hcsg_pkg::stage_type stage,
   input  logic                out_ready,
   output logic                stage_ready,
   output logic                out_valid,
   output logic [1:0]          out_direction,
   output logic                out_last_step
);
   import hcsg_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   dir_type              direction_ff;
   dir_type              direction_in;
   logic                 last_ff;
   logic                 last_in;

   logic [MAX_ORDER:0]   ones_below;
   logic [1:0]           sym_bits;
   logic [1:0]           sel_quad;
   logic [1:0]           join_quad;
   logic [INDEX_W-1:0]   low_mask;
   logic [1:0]           quad;
   logic                 in_range;
   logic                 top_hit;
   dir_type              dir_calc;

   // ones_below[i]: the 2*i low index bits are all ones
   always_comb begin
      for (int i = 0; i <= MAX_ORDER; i++) begin
         low_mask      = ~({INDEX_W{1'b1}} << (2 * i));
         ones_below[i] = ((stage.index & low_mask) == low_mask);
      end
   end

   always_comb begin
      sym_bits = SYM_A;
      sel_quad = 2'd0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         quad     = stage.index[2*i +: 2];
         in_range = (int'(stage.order) >= i + 1);
         // levels above the joining one select sub-blocks
         if (in_range && !ones_below[i]) begin
            sym_bits = sym_bits ^ sym_flip(quad);
         end
         // the joining level is the highest in range with all ones below
         top_hit = (int'(stage.order) == i + 1) || !ones_below[i+1];
         if (in_range && ones_below[i] && top_hit) begin
            sel_quad = sel_quad | quad;
         end
      end
      join_quad = (sel_quad > 2'd2) ? 2'd2 : sel_quad;
      dir_calc  = join_dir(sym_type'(sym_bits), join_quad);
   end

   assign stage_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in     = valid_ff;
      direction_in = direction_ff;
      last_in      = last_ff;
      if (stage_ready) begin
         valid_in     = stage.valid;
         direction_in = dir_calc;
         last_in      = stage.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      direction_ff <= direction_in;
      last_ff      <= last_in;
   end

   assign out_valid     = valid_ff;
   assign out_direction = direction_ff;
   assign out_last_step = last_ff;

endmodule

FILE: hw/rtl/hilbert_curve_step_generator.sv
// ----------------------------------------------------------------------------
// hilbert_curve_step_generator
// Emits the unit-step directions of a Hilbert curve, one per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each request beat (req_ch) yields exactly one response beat (rsp_ch) with
//   the direction of the next step (0, 90, 180 or 270 degrees as 0..3) and a
//   flag on the final step of the curve. After the final step the sequence
//   starts over; a request with restart set begins again at the first step.
//   curve_order is written over the APB-style port at address 0 while the
//   block is idle; 0 acts as order 1 and values above 16 act as order 16.
//   A request beat is registered first in the step counter register, then in
//   the direction output register, before its response is valid.
//   Throughput is one beat per cycle while the receiver takes responses, set
//   by the step counter update (one 32-bit compare and increment per cycle).
//   Reset puts the counter at the first step, empties both stages and sets
//   the order to 1. When the receiver stalls, the output register holds its
//   beat, the middle stage still takes one more request, and req_ch.ready
//   then drops until the response is taken.
// ----------------------------------------------------------------------------
module hilbert_curve_step_generator (
   input  logic                           clock,
   input  logic                           reset,
   hcsg_req_if.sink                       req_ch,
   hcsg_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hcsg_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hcsg_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hcsg_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hcsg_pkg::*;

   logic [CFG_W-1:0] curve_order_ff;
   logic [CFG_W-1:0] curve_order_in;
   logic             csr_write;
   stage_type        stage;
   logic             stage_ready;
   logic             load_en;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      curve_order_in = curve_order_ff;
      if (csr_write && (paddr[2] == CSR_CURVE_ORDER)) begin
         curve_order_in = pwdata[CFG_W-1:0];
      end
      if (paddr[2] == CSR_CURVE_ORDER) begin
         prdata = CSR_DATA_W'(curve_order_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff <= CURVE_ORDER_RESET;
      end else begin
         curve_order_ff <= curve_order_in;
      end
   end

   assign load_en      = !stage.valid || stage_ready;
   assign req_ch.ready = load_en;

   hcsg_index u_index (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_restart  (req_ch.restart),
      .load_en     (load_en),
      .curve_order (curve_order_ff),
      .stage       (stage)
   );

   hcsg_dir u_dir (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .out_ready     (rsp_ch.ready),
      .stage_ready   (stage_ready),
      .out_valid     (rsp_ch.valid),
      .out_direction (rsp_ch.direction),
      .out_last_step (rsp_ch.last_step)
   );

   // request side only backs up when both stages hold beats and output stalls
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (stage.valid && rsp_ch.valid && !rsp_ch.ready))
      else $error("request stalled without a full pipeline");

   a_order_range: assert property (@(posedge clock) disable iff (reset)
      stage.valid |-> (stage.order >= ORDER_W'(1) && stage.order <= ORDER_W'(MAX_ORDER)))
      else $error("effective order out of range");

   // a stage beat moves into the output register when it is free
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage_ready) |=> rsp_ch.valid)
      else $error("stage beat lost on its way to the output");

   a_last_first: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && stage.last && stage.order == ORDER_W'(1)) |-> (stage.index == INDEX_W'(2)))
      else $error("order one curve ends on the wrong step");

endmodule
